[rtl/scfp_pkg.sv]
package scfp_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [7:0] CFG_REPORT_OPCODE = 8'd0;
  localparam logic [7:0] CFG_LIST_OPCODE = 8'd1;
  localparam logic [7:0] REPORT_OPCODE_RST = 8'hF0;
  localparam logic [7:0] LIST_OPCODE_RST = 8'hF1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_LIST = 1'b1;

  typedef enum logic [2:0] {
    TK_LINK,
    TK_NUM,
    TK_START,
    TK_LIST,
    TK_DATA
  } tok_op_t;

  typedef struct packed {
    tok_op_t op;
    logic [7:0] data;
    logic [3:0] len;
    logic [2:0] pos;
    logic last;
  } scfp_tok_t;

endpackage

[rtl/serial_command_frame_parser.sv]
// A byte that completes a frame writes its token to the queue at the accepting edge;
// the output register is then loaded from the queue head once the output can take it.
// Throughput: one byte per cycle; a 4-entry token queue decouples the parser
// from the output register, so bytes stall only when the queue fills.
// Reset (rst_n low, synchronous): parser, queue and output valid cleared;
// opcodes return to 0xF0 (report) and 0xF1 (list).
module serial_command_frame_parser #(
  parameter int MAX_PAYLOAD_BYTES = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] in_rx_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic out_result_kind,
  output logic [7:0] out_link_id,
  output logic [7:0] out_report_number,
  output logic [3:0] out_payload_length,
  output logic [63:0] out_payload_bytes,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import scfp_pkg::*;

  logic [7:0] report_opcode_r, list_opcode_r;
  logic q_full, q_valid, q_pop, tok_push;
  scfp_tok_t push_tok, head_tok;

  assign cfg_ready = 1'b1;
  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_opcode_r <= REPORT_OPCODE_RST;
      list_opcode_r <= LIST_OPCODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REPORT_OPCODE: report_opcode_r <= cfg_data;
        CFG_LIST_OPCODE:   list_opcode_r <= cfg_data;
        default: ;
      endcase
    end
  end

  scfp_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .report_opcode(report_opcode_r),
    .list_opcode(list_opcode_r),
    .tok_push(tok_push),
    .tok(push_tok)
  );

  scfp_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(tok_push),
    .push_tok(push_tok),
    .pop(q_pop),
    .head_tok(head_tok),
    .head_valid(q_valid),
    .full(q_full)
  );

  scfp_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .tok(head_tok),
    .tok_valid(q_valid),
    .tok_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_kind(out_result_kind),
    .out_link_id(out_link_id),
    .out_report_number(out_report_number),
    .out_payload_length(out_payload_length),
    .out_payload_bytes(out_payload_bytes)
  );

endmodule

[rtl/scfp_front.sv]
module scfp_front #(
  parameter int MAX_PAYLOAD_BYTES = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] report_opcode,
  input  logic [7:0] list_opcode,
  output logic tok_push,
  output scfp_pkg::scfp_tok_t tok
);
  import scfp_pkg::*;

  logic [1:0] hdr_pos_r, hdr_pos_nxt;
  logic collect_r, collect_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [3:0] want_r, want_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic acc;
  logic last;
  logic [3:0] clamp_len;

  assign acc = in_valid && !in_stall;
  assign last = (cnt_r + 4'd1) >= want_r;
  assign clamp_len = (in_rx_byte > 8'(MAX_PAYLOAD_BYTES)) ? 4'(MAX_PAYLOAD_BYTES)
                                                          : in_rx_byte[3:0];

  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    collect_nxt = collect_r;
    cmd_nxt = cmd_r;
    want_nxt = want_r;
    cnt_nxt = cnt_r;
    tok_push = 1'b0;
    tok.op = TK_DATA;
    tok.data = in_rx_byte;
    tok.len = want_r;
    tok.pos = cnt_r[2:0];
    tok.last = last;
    if (collect_r) begin
      tok_push = acc;
      if (last) begin
        collect_nxt = 1'b0;
        cnt_nxt = 4'd0;
        want_nxt = 4'd0;
      end else begin
        cnt_nxt = cnt_r + 4'd1;
      end
    end else begin
      case (hdr_pos_r)
        2'd0: begin
          cmd_nxt = in_rx_byte;
          hdr_pos_nxt = 2'd1;
        end
        2'd1: begin
          tok.op = TK_LINK;
          tok_push = acc;
          hdr_pos_nxt = 2'd2;
        end
        2'd2: begin
          tok.op = TK_NUM;
          tok_push = acc;
          hdr_pos_nxt = 2'd3;
        end
        default: begin
          hdr_pos_nxt = 2'd0;
          cnt_nxt = 4'd0;
          want_nxt = 4'd0;
          if (cmd_r == report_opcode) begin
            tok.op = TK_START;
            tok.len = clamp_len;
            tok_push = acc;
            if (clamp_len != 4'd0) begin
              collect_nxt = 1'b1;
              want_nxt = clamp_len;
            end
          end else if (cmd_r == list_opcode) begin
            tok.op = TK_LIST;
            tok_push = acc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r <= 2'd0;
      collect_r <= 1'b0;
      cmd_r <= 8'd0;
      want_r <= 4'd0;
      cnt_r <= 4'd0;
    end else if (acc) begin
      hdr_pos_r <= hdr_pos_nxt;
      collect_r <= collect_nxt;
      cmd_r <= cmd_nxt;
      want_r <= want_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_collect_count: assert property (@(posedge clk) disable iff (!rst_n)
    collect_r |-> (want_r != 4'd0) && (cnt_r < want_r))
    else $error("payload count out of range");
  a_collect_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    collect_r |-> hdr_pos_r == 2'd0)
    else $error("header position set while collecting payload");
`endif

endmodule

[rtl/scfp_queue.sv]
module scfp_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  scfp_pkg::scfp_tok_t push_tok,
  input  logic pop,
  output scfp_pkg::scfp_tok_t head_tok,
  output logic head_valid,
  output logic full
);
  import scfp_pkg::*;

  scfp_tok_t mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0] count_r;

  assign head_tok = mem_r[rd_ptr_r];
  assign head_valid = count_r != '0;
  assign full = count_r == (QAW+1)'(QDEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue pop while empty");
`endif

endmodule

[rtl/scfp_back.sv]
module scfp_back (
  input  logic clk,
  input  logic rst_n,
  input  scfp_pkg::scfp_tok_t tok,
  input  logic tok_valid,
  output logic tok_pop,
  output logic out_valid,
  input  logic out_stall,
  output logic out_result_kind,
  output logic [7:0] out_link_id,
  output logic [7:0] out_report_number,
  output logic [3:0] out_payload_length,
  output logic [63:0] out_payload_bytes
);
  import scfp_pkg::*;

  logic [7:0] link_r, num_r;
  logic [63:0] store_r;
  logic [63:0] merged;
  logic emit;
  logic out_valid_r;
  logic kind_r;
  logic [7:0] olink_r, onum_r;
  logic [3:0] olen_r;
  logic [63:0] odata_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      merged[8*i +: 8] = (tok.pos == 3'(i)) ? tok.data : store_r[8*i +: 8];
    end
  end

  always_comb begin
    case (tok.op)
      TK_START: emit = tok.len == 4'd0;
      TK_LIST:  emit = 1'b1;
      TK_DATA:  emit = tok.last;
      default:  emit = 1'b0;
    endcase
  end

  assign tok_pop = tok_valid && (!emit || !out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      case (tok.op)
        TK_LINK:  link_r <= tok.data;
        TK_NUM:   num_r <= tok.data;
        TK_START: store_r <= '0;
        TK_DATA:  store_r <= merged;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tok_pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && emit) begin
      case (tok.op)
        TK_LIST: begin
          kind_r <= KIND_LIST;
          olink_r <= 8'd0;
          onum_r <= 8'd0;
          olen_r <= 4'd0;
          odata_r <= '0;
        end
        TK_DATA: begin
          kind_r <= KIND_REPORT;
          olink_r <= link_r;
          onum_r <= num_r;
          olen_r <= tok.len;
          odata_r <= merged;
        end
        default: begin
          kind_r <= KIND_REPORT;
          olink_r <= link_r;
          onum_r <= num_r;
          olen_r <= 4'd0;
          odata_r <= '0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_link_id = olink_r;
  assign out_report_number = onum_r;
  assign out_payload_length = olen_r;
  assign out_payload_bytes = odata_r;

endmodule
